// File: src/cke_pkg.sv
// Package for the canonical k-mer extractor: constants, register map and shared types.
// It depends on nothing. The core and the top level import it; the interfaces refer to it by name.
`default_nettype none

package cke_pkg;

  // Window size and field widths.
  localparam int MAX_K       = 32;
  localparam int KLEN_W      = 6;
  localparam int SYM_W       = 8;
  localparam int KMER_W      = 2 * MAX_K;
  localparam int FILL_W      = 6;

  // Configuration port geometry.
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  // Register indexes, taken from paddr word bits.
  localparam logic REG_KMER_LENGTH = 1'b0;

  localparam logic [KLEN_W-1:0] KMER_LENGTH_RESET = 6'd27;

  // Special characters of the FASTA text.
  localparam logic [SYM_W-1:0] SYM_LF     = 8'h0A;
  localparam logic [SYM_W-1:0] SYM_CR     = 8'h0D;
  localparam logic [SYM_W-1:0] SYM_HEADER = 8'h3E;
  localparam logic [SYM_W-1:0] SYM_N      = 8'h4E;

  // Complementing a 2-bit base code flips its upper bit.
  localparam logic [1:0] COMPLEMENT_XOR = 2'b10;

  // What the core produces for one symbol.
  typedef struct packed {
    logic              emit;
    logic [KMER_W-1:0] kmer;
  } cke_result_t;

endpackage

`default_nettype wire

// File: src/cke_if.sv
// Valid/ready channel interfaces for the symbol stream and the k-mer stream.
// Depends on cke_pkg for the payload widths.
`default_nettype none

interface cke_sym_if;
  logic                      valid;
  logic                      ready;
  logic [cke_pkg::SYM_W-1:0] symbol;

  modport source (output valid, output symbol, input ready);
  modport sink   (input valid, input symbol, output ready);
endinterface

interface cke_kmer_if;
  logic                       valid;
  logic                       ready;
  logic [cke_pkg::KMER_W-1:0] canonical_kmer;

  modport source (output valid, output canonical_kmer, input ready);
  modport sink   (input valid, input canonical_kmer, output ready);
endinterface

`default_nettype wire

// File: src/cke_core.sv
// Parsing state and rolling k-mer words of the extractor; one symbol per step.
// Depends on cke_pkg. The top level supplies the step strobe and takes the result.
`default_nettype none

module cke_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        step,
  input  wire logic [cke_pkg::SYM_W-1:0]   symbol,
  input  wire logic [cke_pkg::KLEN_W-1:0]  kmer_length,
  output cke_pkg::cke_result_t             result
);
  import cke_pkg::*;

  logic              in_header;
  logic [FILL_W-1:0] bases_filled;
  logic [KMER_W-1:0] forward_kmer;
  logic [KMER_W-1:0] reverse_kmer;

  logic              in_header_next;
  logic [FILL_W-1:0] bases_filled_next;
  logic [KMER_W-1:0] forward_kmer_next;
  logic [KMER_W-1:0] reverse_kmer_next;

  logic [KLEN_W-1:0] k_eff;
  logic [KMER_W-1:0] mask;
  logic [KMER_W-1:0] rev_shift;
  logic [1:0]        code;
  logic [1:0]        comp;
  logic [FILL_W-1:0] fill_inc;

  // Clamp the length to 1..MAX_K.
  always_comb begin
    if (kmer_length == '0) begin
      k_eff = KLEN_W'(1);
    end else if (kmer_length > KLEN_W'(MAX_K)) begin
      k_eff = KLEN_W'(MAX_K);
    end else begin
      k_eff = kmer_length;
    end
  end

  assign code = symbol[2:1];
  assign comp = code ^ COMPLEMENT_XOR;

  // Window mask, and the reverse word with the new complement merged in at base k-1.
  // After the length shrinks, older bits can still sit there until the mask drops them.
  always_comb begin
    rev_shift = reverse_kmer >> 2;
    for (int i = 0; i < MAX_K; i++) begin
      mask[2*i +: 2] = (KLEN_W'(i) < k_eff) ? 2'b11 : 2'b00;
      if (KLEN_W'(i) == k_eff - KLEN_W'(1)) begin
        rev_shift[2*i +: 2] = rev_shift[2*i +: 2] | comp;
      end
    end
  end

  assign fill_inc = (bases_filled < k_eff) ? bases_filled + FILL_W'(1) : k_eff;

  // Next state and result for the symbol being stepped.
  always_comb begin
    in_header_next    = in_header;
    bases_filled_next = bases_filled;
    forward_kmer_next = forward_kmer;
    reverse_kmer_next = reverse_kmer;
    result.emit       = 1'b0;
    result.kmer       = '0;
    if (in_header) begin
      if (symbol == SYM_LF) begin
        in_header_next = 1'b0;
      end
    end else if (symbol == SYM_LF || symbol == SYM_CR) begin
      in_header_next = 1'b0;
    end else if (symbol == SYM_HEADER) begin
      in_header_next    = 1'b1;
      bases_filled_next = '0;
    end else if (symbol == SYM_N) begin
      bases_filled_next = '0;
    end else begin
      forward_kmer_next = {forward_kmer[KMER_W-3:0], code} & mask;
      reverse_kmer_next = rev_shift & mask;
      bases_filled_next = fill_inc;
      result.emit       = (fill_inc >= k_eff);
      result.kmer       = (forward_kmer_next < reverse_kmer_next) ?
                          forward_kmer_next : reverse_kmer_next;
    end
  end

  // State registers advance only when a symbol is stepped.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_header    <= 1'b0;
      bases_filled <= '0;
      forward_kmer <= '0;
      reverse_kmer <= '0;
    end else if (step) begin
      in_header    <= in_header_next;
      bases_filled <= bases_filled_next;
      forward_kmer <= forward_kmer_next;
      reverse_kmer <= reverse_kmer_next;
    end
  end

endmodule

`default_nettype wire

// File: src/canonical_kmer_extractor.sv
// Top level of the canonical k-mer extractor: channels, input and output registers, APB port.
// Depends on cke_pkg, cke_if.sv and cke_core.
//
// Usage:
//   symbols  (sink)  : one byte of FASTA text per transaction (valid/ready).
//   kmers    (source): one canonical k-mer per transaction, two bits per base,
//                      last base lowest, bits above 2k zero.
//   APB port         : kmer_length at byte address 0 (6 bits, reset 27).
//                      Write it only while the block is idle.
// Headers ('>' through newline), CR, LF and 'N' produce no transaction.
// Path: a k-mer's closing base is held in the input register, and the k-mer it
// closes is then held in the output register, from which kmers presents it.
// Throughput: one symbol per cycle unless the output stalls; the input register and the
// output register each hold one item, and the parsing state updates as each symbol advances.
// Stall: while a k-mer waits on kmers, a symbol that would produce another one
// waits in the input register and symbols ready drops; symbols that produce
// nothing keep flowing.
// Reset (rst, synchronous): empties both registers, leaves header mode, clears
// the fill count and both k-mer words, and sets kmer_length to 27.
`default_nettype none

module canonical_kmer_extractor (
  input  wire logic                              clk,
  input  wire logic                              rst,
  cke_sym_if.sink                                symbols,
  cke_kmer_if.source                             kmers,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [cke_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [cke_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [cke_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                   pready
);
  import cke_pkg::*;

  logic              kmer_length;
  logic [KLEN_W-1:0] kmer_len;
  logic              sym_valid;
  logic [SYM_W-1:0]  sym_reg;
  logic              out_valid;
  logic [KMER_W-1:0] out_kmer;
  logic              advance;
  logic              reg_hit;
  cke_result_t       result;

  // Configuration register, word index from paddr bit 2.
  assign pready      = 1'b1;
  assign reg_hit     = (paddr[2] == REG_KMER_LENGTH);
  assign kmer_length = reg_hit;
  assign prdata      = reg_hit ? {{(APB_DATA_W-KLEN_W){1'b0}}, kmer_len} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_len <= KMER_LENGTH_RESET;
    end else if (psel && penable && pwrite && pready && kmer_length) begin
      kmer_len <= pwdata[KLEN_W-1:0];
    end
  end

  // The held symbol moves on unless it makes a k-mer and the output is blocked.
  assign advance       = sym_valid && (!result.emit || !out_valid || kmers.ready);
  assign symbols.ready = !sym_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      sym_valid <= 1'b0;
    end else if (symbols.ready) begin
      sym_valid <= symbols.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (symbols.valid && symbols.ready) begin
      sym_reg <= symbols.symbol;
    end
  end

  cke_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .symbol      (sym_reg),
    .kmer_length (kmer_len),
    .result      (result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && result.emit) begin
      out_valid <= 1'b1;
    end else if (kmers.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.emit) begin
      out_kmer <= result.kmer;
    end
  end

  assign kmers.valid          = out_valid;
  assign kmers.canonical_kmer = out_kmer;

endmodule

`default_nettype wire
